// ===== rtl/dfs_pkg.sv =====
// ----------------------------------------------------------------------------
// dfs_pkg: shared types and constants for the decimal to 14-segment encoder
// Glyph table, digit count and the record handed from cell to cell.
// ----------------------------------------------------------------------------
package dfs_pkg;

  localparam int unsigned NUM_POS     = 6;
  localparam int unsigned VALUE_W     = 20;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned DIGIT_W     = 4;
  // floor(v / 10) == (v * RECIP_10) >> RECIP_SHIFT for every 20-bit v
  localparam int unsigned RECIP_SHIFT = 23;
  localparam int unsigned RECIP_W     = 20;
  localparam logic [RECIP_W-1:0] RECIP_10 = RECIP_W'(20'hCCCCD);
  localparam int unsigned PROD_W      = VALUE_W + RECIP_W;

  typedef logic [WORD_W-1:0] word_t;

  // Record moving down the chain. words[0] ends up as the units position.
  typedef struct packed {
    logic                      live;   // this and later cells still show digits
    logic [VALUE_W-1:0]        quot;   // remaining quotient
    word_t [NUM_POS-1:0]       words;
  } stage_t;

  function automatic word_t glyph(input logic [DIGIT_W-1:0] d);
    word_t w;
    unique case (d)
      4'd0:    w = 16'hFC28;
      4'd1:    w = 16'h6020;
      4'd2:    w = 16'hDB00;
      4'd3:    w = 16'hF300;
      4'd4:    w = 16'h6700;
      4'd5:    w = 16'hB700;
      4'd6:    w = 16'hBF00;
      4'd7:    w = 16'hE400;
      4'd8:    w = 16'hFF00;
      4'd9:    w = 16'hF700;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/dfs_cell.sv =====
// ----------------------------------------------------------------------------
// dfs_cell: one digit cell of the conversion chain
// Peels one decimal digit off the quotient, shifts its glyph into the word
// row, and registers the record for the next cell.
// ----------------------------------------------------------------------------
module dfs_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  dfs_pkg::stage_t in_stage,
  output logic            out_vld,
  output dfs_pkg::stage_t out_stage
);

  logic [dfs_pkg::PROD_W-1:0]  prod;
  logic [dfs_pkg::VALUE_W-1:0] quot;
  logic [dfs_pkg::VALUE_W-1:0] times10;
  logic [dfs_pkg::DIGIT_W-1:0] digit;
  dfs_pkg::word_t              word;

  logic            vld_r;
  dfs_pkg::stage_t stage_r, stage_nxt;

  // divide by ten through the reciprocal; remainder from q*10 = (q<<3)+(q<<1)
  assign prod    = dfs_pkg::PROD_W'(in_stage.quot) * dfs_pkg::PROD_W'(dfs_pkg::RECIP_10);
  assign quot    = dfs_pkg::VALUE_W'(prod >> dfs_pkg::RECIP_SHIFT);
  assign times10 = (quot << 3) + (quot << 1);
  assign digit   = dfs_pkg::DIGIT_W'(in_stage.quot - times10);
  assign word    = in_stage.live ? dfs_pkg::glyph(digit) : '0;

  always_comb begin
    stage_nxt       = in_stage;
    stage_nxt.live  = in_stage.live && (quot != '0);
    stage_nxt.quot  = quot;
    stage_nxt.words = {word, in_stage.words[dfs_pkg::NUM_POS-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

  assign out_vld   = vld_r;
  assign out_stage = stage_r;

endmodule

// ===== rtl/decimal_to_fourteen_segment.sv =====
// ----------------------------------------------------------------------------
// decimal_to_fourteen_segment: value to six 14-segment display words
// Six digit cells in a row, units first; leading positions blank.
// ----------------------------------------------------------------------------
//  channel   ports                           handshake
//  input     in_value[19:0]                  start / busy (busy is always low)
//  result    out_word_pos1..6[15:0]          out_valid strobe, one cycle
//
//  One value per cycle; each result is registered once in each of the six
//  digit cells of the chain.
//  Reset (rst_n low, synchronous) clears the cell valid flags only.
//  The receiver cannot stall, so the chain never holds and busy stays low.
// ----------------------------------------------------------------------------
module decimal_to_fourteen_segment (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [19:0] in_value,
  output logic        out_valid,
  output logic [15:0] out_word_pos1,
  output logic [15:0] out_word_pos2,
  output logic [15:0] out_word_pos3,
  output logic [15:0] out_word_pos4,
  output logic [15:0] out_word_pos5,
  output logic [15:0] out_word_pos6
);

  logic            vld   [dfs_pkg::NUM_POS+1];
  dfs_pkg::stage_t stage [dfs_pkg::NUM_POS+1];

  assign busy        = 1'b0;
  assign vld[0]      = start;
  assign stage[0]    = '{live: 1'b1, quot: in_value, words: '0};

  for (genvar i = 0; i < dfs_pkg::NUM_POS; i++) begin : g_cell
    dfs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_vld    (vld[i]),
      .in_stage  (stage[i]),
      .out_vld   (vld[i+1]),
      .out_stage (stage[i+1])
    );
  end

  assign out_valid     = vld[dfs_pkg::NUM_POS];
  assign out_word_pos6 = stage[dfs_pkg::NUM_POS].words[0];
  assign out_word_pos5 = stage[dfs_pkg::NUM_POS].words[1];
  assign out_word_pos4 = stage[dfs_pkg::NUM_POS].words[2];
  assign out_word_pos3 = stage[dfs_pkg::NUM_POS].words[3];
  assign out_word_pos2 = stage[dfs_pkg::NUM_POS].words[4];
  assign out_word_pos1 = stage[dfs_pkg::NUM_POS].words[5];

endmodule

// ===== rtl/dfs_checker.sv =====
// ----------------------------------------------------------------------------
// dfs_checker: port-level checks for the 14-segment encoder
// Latency, blanking order and units glyph, bound to the top level.
// ----------------------------------------------------------------------------
module dfs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [15:0] out_word_pos1,
  input logic [15:0] out_word_pos2,
  input logic [15:0] out_word_pos3,
  input logic [15:0] out_word_pos4,
  input logic [15:0] out_word_pos5,
  input logic [15:0] out_word_pos6
);

  // every transfer yields a result at the end of the cell chain
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##6 out_valid)
    else $error("result missing six cycles after transfer");

  // no result without a matching earlier transfer
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 6))
    else $error("result without matching transfer");

  a_units: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word_pos6 != 16'h0000))
    else $error("units position blank");

  // blanking only runs from the left: a blank pos5 has blanks in pos4 to pos1
  a_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word_pos5 == 16'h0000)) |->
      (out_word_pos4 == 16'h0000 && out_word_pos3 == 16'h0000 &&
       out_word_pos2 == 16'h0000 && out_word_pos1 == 16'h0000))
    else $error("digit shown left of a blank position");

endmodule

bind decimal_to_fourteen_segment dfs_checker u_dfs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_word_pos1 (out_word_pos1),
  .out_word_pos2 (out_word_pos2),
  .out_word_pos3 (out_word_pos3),
  .out_word_pos4 (out_word_pos4),
  .out_word_pos5 (out_word_pos5),
  .out_word_pos6 (out_word_pos6)
);

// ===== tb/decimal_to_fourteen_segment_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_to_fourteen_segment_tb: self-checking bench for the 14-segment encoder
// Drives values through the start/busy port with random gaps and compares
// every out_valid strobe, field by field, with a predicted six-word display.
// ----------------------------------------------------------------------------
module decimal_to_fourteen_segment_tb;

  typedef struct {
    dfs_pkg::word_t pos1;
    dfs_pkg::word_t pos2;
    dfs_pkg::word_t pos3;
    dfs_pkg::word_t pos4;
    dfs_pkg::word_t pos5;
    dfs_pkg::word_t pos6;
  } display_t;

  class display_scoreboard;
    display_t       pending_displays[$];
    dfs_pkg::word_t seg_glyph [10];
    int unsigned    mismatches;

    function new();
      seg_glyph = '{16'hFC28, 16'h6020, 16'hDB00, 16'hF300, 16'h6700,
                    16'hB700, 16'hBF00, 16'hE400, 16'hFF00, 16'hF700};
      mismatches = 0;
    endfunction

    // Digits go in units first; stop once the quotient runs out.
    function display_t encode_value(logic [dfs_pkg::VALUE_W-1:0] value);
      dfs_pkg::word_t words [dfs_pkg::NUM_POS];
      int unsigned    quot;
      bit             live;
      display_t       disp;
      quot = value;
      live = 1'b1;
      for (int k = 0; k < dfs_pkg::NUM_POS; k++) begin
        words[k] = '0;
      end
      for (int k = 0; k < dfs_pkg::NUM_POS; k++) begin
        if (live) begin
          words[dfs_pkg::NUM_POS-1-k] = seg_glyph[quot % 10];
          quot = quot / 10;
          if (quot == 0) live = 1'b0;
        end
      end
      disp.pos1 = words[0];
      disp.pos2 = words[1];
      disp.pos3 = words[2];
      disp.pos4 = words[3];
      disp.pos5 = words[4];
      disp.pos6 = words[5];
      return disp;
    endfunction

    function void note_value(logic [dfs_pkg::VALUE_W-1:0] value);
      pending_displays.push_back(encode_value(value));
    endfunction

    function int pending_count();
      return pending_displays.size();
    endfunction

    task report(string msg);
      mismatches++;
      $display("%0t ns: %s", $time, msg);
    endtask

    task check_display(display_t got);
      display_t want;
      if (pending_displays.size() == 0) begin
        report("result strobe with no transfer outstanding");
      end else begin
        want = pending_displays.pop_front();
        if (got.pos1 !== want.pos1)
          report($sformatf("mismatch on word_pos1: got %h, expected %h", got.pos1, want.pos1));
        if (got.pos2 !== want.pos2)
          report($sformatf("mismatch on word_pos2: got %h, expected %h", got.pos2, want.pos2));
        if (got.pos3 !== want.pos3)
          report($sformatf("mismatch on word_pos3: got %h, expected %h", got.pos3, want.pos3));
        if (got.pos4 !== want.pos4)
          report($sformatf("mismatch on word_pos4: got %h, expected %h", got.pos4, want.pos4));
        if (got.pos5 !== want.pos5)
          report($sformatf("mismatch on word_pos5: got %h, expected %h", got.pos5, want.pos5));
        if (got.pos6 !== want.pos6)
          report($sformatf("mismatch on word_pos6: got %h, expected %h", got.pos6, want.pos6));
      end
    endtask
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic [dfs_pkg::VALUE_W-1:0] in_value;
  logic                        out_valid;
  dfs_pkg::word_t              out_word_pos1;
  dfs_pkg::word_t              out_word_pos2;
  dfs_pkg::word_t              out_word_pos3;
  dfs_pkg::word_t              out_word_pos4;
  dfs_pkg::word_t              out_word_pos5;
  dfs_pkg::word_t              out_word_pos6;

  display_scoreboard sb = new();

  decimal_to_fourteen_segment uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_word_pos1 (out_word_pos1),
    .out_word_pos2 (out_word_pos2),
    .out_word_pos3 (out_word_pos3),
    .out_word_pos4 (out_word_pos4),
    .out_word_pos5 (out_word_pos5),
    .out_word_pos6 (out_word_pos6)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Input transfer noted before the result check so a result in the transfer's own cycle still lines up.
  always @(posedge clk) begin
    display_t got;
    if (rst_n && start && !busy) sb.note_value(in_value);
    if (rst_n && out_valid) begin
      got.pos1 = out_word_pos1;
      got.pos2 = out_word_pos2;
      got.pos3 = out_word_pos3;
      got.pos4 = out_word_pos4;
      got.pos5 = out_word_pos5;
      got.pos6 = out_word_pos6;
      sb.check_display(got);
    end
  end

  // Holds start high until the transfer happens; start is left high.
  task send_value(input logic [dfs_pkg::VALUE_W-1:0] value);
    start    <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (busy);
  endtask

  task idle_cycles(input int unsigned n);
    if (n > 0) begin
      start    <= 1'b0;
      in_value <= dfs_pkg::VALUE_W'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  function int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    else if (r < 90) return $urandom_range(3, 1);
    else return $urandom_range(30, 4);
  endfunction

  task wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending_count() != 0);
  endtask

  // Values spread over every digit count, plus wraps past a million.
  function logic [dfs_pkg::VALUE_W-1:0] pick_value();
    int unsigned r;
    int unsigned ndig;
    int unsigned lo;
    int unsigned hi;
    r = $urandom_range(99);
    if (r < 15) return dfs_pkg::VALUE_W'($urandom);
    else if (r < 30) return dfs_pkg::VALUE_W'($urandom_range(1048575, 1000000));
    else begin
      ndig = $urandom_range(6, 1);
      lo = (ndig == 1) ? 0 : 10 ** (ndig - 1);
      hi = 10 ** ndig - 1;
      return dfs_pkg::VALUE_W'($urandom_range(hi, lo));
    end
  endfunction

  logic [dfs_pkg::VALUE_W-1:0] directed_values [] = '{
    20'd0, 20'd1, 20'd9, 20'd10, 20'd99, 20'd100, 20'd999, 20'd1000,
    20'd10000, 20'd100000, 20'd999999, 20'd1000000, 20'd1000005, 20'd1048575,
    20'd123456, 20'd987650, 20'd524288, 20'd7, 20'd42, 20'd80808, 20'd1010101
  };

  initial begin
    int unsigned burst;
    start    <= 1'b0;
    in_value <= '0;
    rst_n    <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_values[i]) begin
      send_value(directed_values[i]);
      idle_cycles(pick_gap());
    end

    for (int i = 0; i < 650; i++) begin
      send_value(pick_value());
      if (i == 300) wait_drained();
      else if (burst > 0) burst--;
      else if ($urandom_range(49) == 0) burst = $urandom_range(60, 20);
      else idle_cycles(pick_gap());
    end

    wait_drained();
    repeat (12) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout waiting for results");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/dfs_pkg.sv
rtl/dfs_cell.sv
rtl/decimal_to_fourteen_segment.sv
rtl/dfs_checker.sv
tb/decimal_to_fourteen_segment_tb.sv
